// ===== src/rbmc_pkg.sv =====
`timescale 1ns / 1ps

package rbmc_pkg;

   localparam int TIME_WIDTH_DEF = 32;

   localparam int NOW_WIDTH      = 32;
   localparam int BAT_WIDTH      = 7;
   localparam int REPORT_WIDTH   = 27;
   localparam int SOS_WIDTH      = 22;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 27;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REPORT_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SOS_INTERVAL    = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LOW_BATTERY     = 2'd2;

   localparam logic [REPORT_WIDTH-1:0] DEF_REPORT_INTERVAL = 27'd300000;
   localparam logic [SOS_WIDTH-1:0]    DEF_SOS_INTERVAL    = 22'd30000;
   localparam logic [BAT_WIDTH-1:0]    DEF_LOW_BATTERY     = 7'd15;

   localparam int FALL_HOLD_MS     = 500;
   localparam int KEY_HOLD_MS      = 2000;
   localparam int BLINK_LOCATE_MS  = 500;
   localparam int BLINK_REPORT_MS  = 125;
   localparam int BLINK_SOS_MS     = 200;
   localparam int BLINK_LOWBAT_MS  = 1000;

   localparam logic [BAT_WIDTH-1:0] BAT_HIGH = 7'd50;
   localparam logic [BAT_WIDTH-1:0] BAT_MID  = 7'd20;

   // battery led phase: now mod 1000 through a reciprocal multiply
   localparam int MOD_BASE    = 1000;
   localparam int MOD_SHIFT   = 38;
   localparam int MAGIC_WIDTH = 29;
   localparam logic [MAGIC_WIDTH-1:0] MOD_MAGIC = 29'd274877906;
   localparam int QUOT_WIDTH  = NOW_WIDTH + MAGIC_WIDTH - MOD_SHIFT;
   localparam int REM_WIDTH   = 11;
   localparam logic [REM_WIDTH-1:0] PHASE_MID_MS = 11'd500;
   localparam logic [REM_WIDTH-1:0] PHASE_LOW_MS = 11'd200;

   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_INIT      = 3'd1,
      MODE_LOCATING  = 3'd2,
      MODE_REPORTING = 3'd3,
      MODE_SOS       = 3'd4,
      MODE_LOWBAT    = 3'd5,
      MODE_CHARGING  = 3'd6
   } mode_type;

   typedef struct packed {
      logic [REPORT_WIDTH-1:0] report_interval;
      logic [SOS_WIDTH-1:0]    sos_interval;
      logic [BAT_WIDTH-1:0]    low_battery;
   } cfg_type;

   typedef struct packed {
      logic                 fall_detected;
      logic                 magnet_key;
      logic                 gnss_fix;
      logic                 position_valid;
      logic [BAT_WIDTH-1:0] battery_percent;
      logic                 usb_present;
   } flags_type;

   typedef struct packed {
      mode_type mode;
      logic     gnss_power;
      logic     radio_power;
      logic     led_one;
      logic     led_two;
      logic     led_three;
      logic     send_position;
      logic     sos_latched;
   } result_type;

endpackage

// ===== src/rbmc_csr.sv =====
`timescale 1ns / 1ps

module rbmc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [rbmc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [rbmc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output rbmc_pkg::cfg_type                    cfg
);
   import rbmc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_REPORT_INTERVAL: cfg_in.report_interval = csr_wdata[REPORT_WIDTH-1:0];
            CSR_SOS_INTERVAL:    cfg_in.sos_interval    = csr_wdata[SOS_WIDTH-1:0];
            CSR_LOW_BATTERY:     cfg_in.low_battery     = csr_wdata[BAT_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.report_interval <= DEF_REPORT_INTERVAL;
         cfg_ff.sos_interval    <= DEF_SOS_INTERVAL;
         cfg_ff.low_battery     <= DEF_LOW_BATTERY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/rbmc_ingress.sv =====
`timescale 1ns / 1ps

module rbmc_ingress #(
   parameter int TIME_WIDTH = rbmc_pkg::TIME_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rbmc_pkg::NOW_WIDTH-1:0]      req_now_ms,
   input  rbmc_pkg::flags_type                 req_flags,
   input  logic                                take,
   output logic                                item_valid,
   output logic [TIME_WIDTH-1:0]               item_now,
   output logic [rbmc_pkg::QUOT_WIDTH-1:0]     item_quot,
   output rbmc_pkg::flags_type                 item_flags
);
   import rbmc_pkg::*;

   localparam int EXT_WIDTH  = (TIME_WIDTH > NOW_WIDTH) ? TIME_WIDTH : NOW_WIDTH;
   localparam int PROD_WIDTH = NOW_WIDTH + MAGIC_WIDTH;

   logic                    valid_ff;
   logic                    valid_in;
   logic [TIME_WIDTH-1:0]   now_ff;
   logic [QUOT_WIDTH-1:0]   quot_ff;
   flags_type               flags_ff;

   logic [EXT_WIDTH-1:0]    now_ext;
   logic [TIME_WIDTH-1:0]   now_masked;
   logic [NOW_WIDTH-1:0]    now_phase;
   logic [PROD_WIDTH-1:0]   product;
   logic                    accept;

   assign now_ext    = EXT_WIDTH'(req_now_ms);
   assign now_masked = now_ext[TIME_WIDTH-1:0];
   assign now_phase  = NOW_WIDTH'(now_masked);
   // quotient by 1000, low by at most one; the core corrects it
   assign product    = PROD_WIDTH'(now_phase) * PROD_WIDTH'(MOD_MAGIC);

   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;
   assign valid_in  = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         now_ff   <= now_masked;
         quot_ff  <= product[MOD_SHIFT +: QUOT_WIDTH];
         flags_ff <= req_flags;
      end
   end

   assign item_valid = valid_ff;
   assign item_now   = now_ff;
   assign item_quot  = quot_ff;
   assign item_flags = flags_ff;

endmodule

// ===== src/rbmc_core.sv =====
`timescale 1ns / 1ps

module rbmc_core #(
   parameter int TIME_WIDTH = rbmc_pkg::TIME_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rbmc_pkg::cfg_type                 cfg,
   input  logic                              item_valid,
   input  logic [TIME_WIDTH-1:0]             item_now,
   input  logic [rbmc_pkg::QUOT_WIDTH-1:0]   item_quot,
   input  rbmc_pkg::flags_type               item_flags,
   output logic                              take,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rbmc_pkg::result_type              result
);
   import rbmc_pkg::*;

   localparam int CMP_WIDTH = (TIME_WIDTH > REPORT_WIDTH) ? TIME_WIDTH : REPORT_WIDTH;

   typedef struct packed {
      mode_type              mode;
      logic [TIME_WIDTH-1:0] last_report;
      logic                  sos;
      logic [TIME_WIDTH-1:0] blink_time;
      logic                  led_one;
      logic                  led_three;
      logic [TIME_WIDTH-1:0] fall_start;
      logic                  fall_prev;
      logic [TIME_WIDTH-1:0] key_start;
      logic                  key_prev;
      logic                  key_fired;
      logic                  powered;
      logic                  gnss_power;
      logic                  radio_power;
   } state_type;

   localparam state_type STATE_RESET = '{mode: MODE_INIT, default: '0};

   state_type             state_ff;
   state_type             state_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   result_type            result_ff;
   result_type            result_in;

   logic [TIME_WIDTH-1:0] el_fall;
   logic [TIME_WIDTH-1:0] el_key;
   logic [TIME_WIDTH-1:0] el_blink;
   logic [TIME_WIDTH-1:0] el_report;
   logic [CMP_WIDTH-1:0]  el_report_ext;
   logic [CMP_WIDTH-1:0]  interval;
   logic                  send;
   logic                  low;
   logic                  led_two;
   logic [NOW_WIDTH-1:0]  quot_scaled;
   logic [NOW_WIDTH-1:0]  rem_full;
   logic [REM_WIDTH-1:0]  rem_raw;
   logic [REM_WIDTH-1:0]  phase;
   logic                  rem_over;
   logic                  quot_odd;

   assign take         = item_valid && (!out_valid_ff || rsp_ready);
   assign out_valid_in = take || (out_valid_ff && !rsp_ready);

   // battery led phase: now mod 1000 and the parity of now / 1000
   always_comb begin
      quot_scaled = NOW_WIDTH'(item_quot) * NOW_WIDTH'(MOD_BASE);
      rem_full    = NOW_WIDTH'(item_now) - quot_scaled;
      rem_raw     = rem_full[REM_WIDTH-1:0];
      rem_over    = rem_raw >= REM_WIDTH'(MOD_BASE);
      phase       = rem_over ? rem_raw - REM_WIDTH'(MOD_BASE) : rem_raw;
      quot_odd    = item_quot[0] ^ rem_over;
      if (item_flags.battery_percent > BAT_HIGH) begin
         led_two = 1'b1;
      end else if (item_flags.battery_percent > BAT_MID) begin
         led_two = phase < PHASE_MID_MS;
      end else begin
         led_two = !quot_odd && (phase < PHASE_LOW_MS);
      end
   end

   always_comb begin
      state_in      = state_ff;
      send          = 1'b0;
      low           = item_flags.battery_percent < cfg.low_battery;
      interval      = '0;

      // fall debounce, latches sos once
      if (item_flags.fall_detected && !state_ff.fall_prev) begin
         state_in.fall_start = item_now;
      end
      el_fall = item_now - state_in.fall_start;
      if (item_flags.fall_detected && (el_fall > TIME_WIDTH'(FALL_HOLD_MS))
          && !state_in.sos) begin
         state_in.sos         = 1'b1;
         state_in.mode        = MODE_SOS;
         state_in.last_report = '0;
         state_in.gnss_power  = 1'b1;
         state_in.radio_power = 1'b1;
      end
      state_in.fall_prev = item_flags.fall_detected;

      // magnet key long press toggles power
      if (item_flags.magnet_key && !state_ff.key_prev) begin
         state_in.key_start = item_now;
         state_in.key_fired = 1'b0;
      end
      el_key = item_now - state_in.key_start;
      if (item_flags.magnet_key && !state_in.key_fired
          && (el_key > TIME_WIDTH'(KEY_HOLD_MS))) begin
         state_in.key_fired = 1'b1;
         state_in.powered   = !state_ff.powered;
         if (state_ff.powered) begin
            state_in.gnss_power  = 1'b0;
            state_in.radio_power = 1'b0;
            state_in.mode        = MODE_IDLE;
         end else begin
            state_in.mode = MODE_INIT;
         end
      end
      if (!item_flags.magnet_key) begin
         state_in.key_fired = 1'b0;
      end
      state_in.key_prev = item_flags.magnet_key;

      // status leds
      el_blink = item_now - state_ff.blink_time;
      case (state_in.mode)
         MODE_LOCATING: begin
            if (el_blink >= TIME_WIDTH'(BLINK_LOCATE_MS)) begin
               state_in.blink_time = item_now;
               state_in.led_one    = !state_ff.led_one;
            end
         end
         MODE_REPORTING: begin
            if (el_blink >= TIME_WIDTH'(BLINK_REPORT_MS)) begin
               state_in.blink_time = item_now;
               state_in.led_one    = !state_ff.led_one;
            end
         end
         MODE_SOS: begin
            if (el_blink >= TIME_WIDTH'(BLINK_SOS_MS)) begin
               state_in.blink_time = item_now;
               state_in.led_one    = !state_ff.led_one;
               state_in.led_three  = !state_ff.led_three;
            end
         end
         MODE_CHARGING: begin
            state_in.led_one = 1'b1;
         end
         MODE_LOWBAT: begin
            if (el_blink >= TIME_WIDTH'(BLINK_LOWBAT_MS)) begin
               state_in.blink_time = item_now;
            end
         end
         default: begin
            state_in.led_one   = 1'b0;
            state_in.led_three = 1'b0;
         end
      endcase

      // mode machine
      el_report     = item_now - state_in.last_report;
      el_report_ext = CMP_WIDTH'(el_report);
      case (state_in.mode)
         MODE_INIT: begin
            state_in.gnss_power = 1'b1;
            state_in.mode       = MODE_LOCATING;
         end
         MODE_LOCATING: begin
            if (item_flags.gnss_fix) begin
               state_in.radio_power = 1'b1;
               state_in.mode        = MODE_REPORTING;
            end
            if (low) begin
               state_in.mode = MODE_LOWBAT;
            end
         end
         MODE_REPORTING: begin
            interval = state_in.sos ? CMP_WIDTH'(cfg.sos_interval)
                                    : CMP_WIDTH'(cfg.report_interval);
            if (el_report_ext >= interval) begin
               send                 = item_flags.position_valid;
               state_in.last_report = item_now;
            end
            if (low) begin
               state_in.mode = MODE_LOWBAT;
            end
         end
         MODE_SOS: begin
            interval = CMP_WIDTH'(cfg.sos_interval);
            if (el_report_ext >= interval) begin
               send                 = item_flags.position_valid;
               state_in.last_report = item_now;
            end
         end
         MODE_LOWBAT: begin
            state_in.gnss_power  = 1'b0;
            state_in.radio_power = 1'b0;
            if (item_flags.usb_present) begin
               state_in.mode = MODE_CHARGING;
            end
         end
         MODE_CHARGING: begin
            if (!item_flags.usb_present) begin
               state_in.mode = MODE_INIT;
            end
         end
         default: begin
            state_in.mode = state_in.mode;
         end
      endcase

      result_in.mode          = state_in.mode;
      result_in.gnss_power    = state_in.gnss_power;
      result_in.radio_power   = state_in.radio_power;
      result_in.led_one       = state_in.led_one;
      result_in.led_two       = led_two;
      result_in.led_three     = state_in.led_three;
      result_in.send_position = send;
      result_in.sos_latched   = state_in.sos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (take) begin
            state_ff <= state_in;
         end
      end
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign result    = result_ff;

endmodule

// ===== src/rescue_beacon_mode_controller.sv =====
`timescale 1ns / 1ps

// channel   | ports   | handshake    | moves
// ----------+---------+--------------+--------------------------------------
// request   | req_*   | valid/ready  | one poll: time and sampled signals
// response  | rsp_*   | valid/ready  | mode, power, leds, send strobe, sos
// csr       | csr_*   | write enable | interval and battery threshold writes
//
// one transaction per cycle sustained while rsp_ready stays high; a poll passes
// the input register, then the result register, before its response is valid.
// the reciprocal multiply for now / 1000 sits before the input register; the
// core multiplies back by the constant 1000 and corrects the quotient for the
// battery led phase. all state updates in one pass ahead of the result register.
// a stalled response holds and one more poll waits in the input register.
// synchronous reset puts the mode machine in init and the intervals to defaults.

module rescue_beacon_mode_controller #(
   parameter int TIME_WIDTH = rbmc_pkg::TIME_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rbmc_pkg::NOW_WIDTH-1:0]      req_now_ms,
   input  logic                                req_fall_detected,
   input  logic                                req_magnet_key,
   input  logic                                req_gnss_fix,
   input  logic                                req_position_valid,
   input  logic [rbmc_pkg::BAT_WIDTH-1:0]      req_battery_percent,
   input  logic                                req_usb_present,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_mode,
   output logic                                rsp_gnss_power,
   output logic                                rsp_radio_power,
   output logic                                rsp_led_one,
   output logic                                rsp_led_two,
   output logic                                rsp_led_three,
   output logic                                rsp_send_position,
   output logic                                rsp_sos_latched,
   input  logic                                csr_write_en,
   input  logic [rbmc_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [rbmc_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);
   import rbmc_pkg::*;

   cfg_type               cfg;
   flags_type             req_flags;
   logic                  take;
   logic                  item_valid;
   logic [TIME_WIDTH-1:0] item_now;
   logic [QUOT_WIDTH-1:0] item_quot;
   flags_type             item_flags;
   result_type            result;

   assign req_flags.fall_detected   = req_fall_detected;
   assign req_flags.magnet_key      = req_magnet_key;
   assign req_flags.gnss_fix        = req_gnss_fix;
   assign req_flags.position_valid  = req_position_valid;
   assign req_flags.battery_percent = req_battery_percent;
   assign req_flags.usb_present     = req_usb_present;

   rbmc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rbmc_ingress #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_now_ms (req_now_ms),
      .req_flags  (req_flags),
      .take       (take),
      .item_valid (item_valid),
      .item_now   (item_now),
      .item_quot  (item_quot),
      .item_flags (item_flags)
   );

   rbmc_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item_now   (item_now),
      .item_quot  (item_quot),
      .item_flags (item_flags),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .result     (result)
   );

   assign rsp_mode          = result.mode;
   assign rsp_gnss_power    = result.gnss_power;
   assign rsp_radio_power   = result.radio_power;
   assign rsp_led_one       = result.led_one;
   assign rsp_led_two       = result.led_two;
   assign rsp_led_three     = result.led_three;
   assign rsp_send_position = result.send_position;
   assign rsp_sos_latched   = result.sos_latched;

endmodule

// ===== src/rbmc_checker.sv =====
`timescale 1ns / 1ps

module rbmc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [2:0]                          rsp_mode,
   input logic                                rsp_gnss_power,
   input logic                                rsp_radio_power,
   input logic                                rsp_send_position,
   input logic                                rsp_sos_latched
);
   import rbmc_pkg::*;

   // a stalled response transaction keeps its mode, send strobe and sos latch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode)
         && $stable(rsp_send_position) && $stable(rsp_sos_latched))
      else $error("stalled response changed");

   // position requests come from reporting or sos; reporting may drop to low battery
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_position |->
         (rsp_mode == MODE_REPORTING) || (rsp_mode == MODE_SOS)
         || (rsp_mode == MODE_LOWBAT))
      else $error("send strobe outside reporting, sos or low battery");

   // sos mode is only reached through the latch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == MODE_SOS) |-> rsp_sos_latched)
      else $error("sos mode without sos latched");

   // key power-off leaves both modules unpowered while idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == MODE_IDLE) |-> !rsp_gnss_power && !rsp_radio_power)
      else $error("module powered in idle");

endmodule

bind rescue_beacon_mode_controller rbmc_checker u_rbmc_checker (.*);
